// File: hdl/vn_pkg.sv
// Package with shared types and constants for the vector normalizer.
package vn_pkg;
  localparam int unsigned CompW = 16;
  localparam int unsigned SumW = 34;
  localparam int unsigned RootW = 17;
  localparam int unsigned QuotW = 17;
  localparam int unsigned DivBits = 30;
  localparam int unsigned FracShift = 14;
  localparam int unsigned DefaultQueueDepth = 4;

  typedef struct packed {
    logic [CompW-1:0] ax;
    logic [CompW-1:0] ay;
    logic [CompW-1:0] az;
    logic             sx;
    logic             sy;
    logic             sz;
    logic [SumW-1:0]  sum;
  } vn_front_t;
endpackage

// File: hdl/vn_front.sv
// Front stage: takes absolute values, squares and sums them into a registered beat.
module vn_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] z_i,
  input  logic               stall_i,
  output logic               valid_o,
  output vn_pkg::vn_front_t  data_o
);
  import vn_pkg::*;

  logic [CompW-1:0] ax, ay, az;
  logic [31:0] sqx_q, sqy_q, sqz_q;
  logic [CompW-1:0] ax_q, ay_q, az_q;
  logic sx_q, sy_q, sz_q, v1_q, v2_q;
  vn_front_t data_q;

  assign ax = x_i[15] ? CompW'(-x_i) : x_i;
  assign ay = y_i[15] ? CompW'(-y_i) : y_i;
  assign az = z_i[15] ? CompW'(-z_i) : z_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (!stall_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      sqx_q <= ax * ax;
      sqy_q <= ay * ay;
      sqz_q <= az * az;
      ax_q <= ax;
      ay_q <= ay;
      az_q <= az;
      sx_q <= x_i[15];
      sy_q <= y_i[15];
      sz_q <= z_i[15];
      data_q.ax <= ax_q;
      data_q.ay <= ay_q;
      data_q.az <= az_q;
      data_q.sx <= sx_q;
      data_q.sy <= sy_q;
      data_q.sz <= sz_q;
      data_q.sum <= SumW'(sqx_q) + SumW'(sqy_q) + SumW'(sqz_q);
    end
  end

  assign valid_o = v2_q;
  assign data_o = data_q;
endmodule

// File: hdl/vn_queue.sv
// Small queue that decouples the front stage from the back pipeline.
module vn_queue #(
  parameter int unsigned Depth = vn_pkg::DefaultQueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vn_pkg::vn_front_t data_i,
  output logic              full_o,
  output logic              empty_o,
  input  logic              pop_i,
  output vn_pkg::vn_front_t data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import vn_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  vn_front_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign full_o = cnt_q == CW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o = mem_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop) rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end
endmodule

// File: hdl/vn_back.sv
// Back pipeline: square root one bit per stage, then three restoring dividers.
module vn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  vn_pkg::vn_front_t data_i,
  input  logic              stall_i,
  output logic              valid_o,
  output logic [15:0]       unit_x_o,
  output logic [15:0]       unit_y_o,
  output logic [15:0]       unit_z_o,
  output logic [15:0]       magnitude_o,
  output logic              zero_length_o
);
  import vn_pkg::*;
  localparam int unsigned SqS = 16;
  localparam int unsigned Tot = SqS + DivBits;
  localparam int unsigned NumW = CompW + FracShift;

  logic [Tot-1:0] v_q;
  vn_front_t f_q [SqS+1];
  logic [SumW-1:0] rem_q [SqS+1];
  logic [SumW-1:0] root_q [SqS+1];

  logic [RootW-1:0] len_q [DivBits+1];
  logic [NumW-1:0] nx_q [DivBits+1], ny_q [DivBits+1], nz_q [DivBits+1];
  logic [RootW:0] rx_q [DivBits+1], ry_q [DivBits+1], rz_q [DivBits+1];
  logic [2:0] sg_q [DivBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (!stall_i) v_q <= {v_q[Tot-2:0], valid_i};
  end

  always_comb begin
    f_q[0] = data_i;
    rem_q[0] = data_i.sum;
    root_q[0] = '0;
  end

  for (genvar i = 0; i < SqS; i++) begin : g_sq
    localparam logic [SumW-1:0] Bit = SumW'(1) << (2 * (SqS - 1 - i));
    logic [SumW-1:0] trial;
    assign trial = root_q[i] + Bit;
    always_ff @(posedge clk_i) begin
      if (!stall_i) begin
        f_q[i+1] <= f_q[i];
        if (rem_q[i] >= trial) begin
          rem_q[i+1] <= rem_q[i] - trial;
          root_q[i+1] <= (root_q[i] >> 1) + Bit;
        end else begin
          rem_q[i+1] <= rem_q[i];
          root_q[i+1] <= root_q[i] >> 1;
        end
      end
    end
  end

  always_comb begin
    len_q[0] = RootW'(root_q[SqS]);
    nx_q[0] = {f_q[SqS].ax, FracShift'(0)};
    ny_q[0] = {f_q[SqS].ay, FracShift'(0)};
    nz_q[0] = {f_q[SqS].az, FracShift'(0)};
    rx_q[0] = '0;
    ry_q[0] = '0;
    rz_q[0] = '0;
    sg_q[0] = {f_q[SqS].sz, f_q[SqS].sy, f_q[SqS].sx};
  end

  function automatic logic [RootW+1:0] div_step(logic [RootW:0] r, logic b,
                                                logic [RootW-1:0] d);
    logic [RootW+1:0] t;
    logic [RootW+1:0] s;
    t = {r, b};
    s = t - {2'b00, d};
    if (t >= {2'b00, d}) return {s[RootW:0], 1'b1};
    return {t[RootW:0], 1'b0};
  endfunction

  for (genvar j = 0; j < DivBits; j++) begin : g_div
    logic [RootW+1:0] sx, sy, sz;
    assign sx = div_step(rx_q[j], nx_q[j][NumW-1], len_q[j]);
    assign sy = div_step(ry_q[j], ny_q[j][NumW-1], len_q[j]);
    assign sz = div_step(rz_q[j], nz_q[j][NumW-1], len_q[j]);
    always_ff @(posedge clk_i) begin
      if (!stall_i) begin
        len_q[j+1] <= len_q[j];
        sg_q[j+1] <= sg_q[j];
        rx_q[j+1] <= sx[RootW+1:1];
        ry_q[j+1] <= sy[RootW+1:1];
        rz_q[j+1] <= sz[RootW+1:1];
        nx_q[j+1] <= {nx_q[j][NumW-2:0], sx[0]};
        ny_q[j+1] <= {ny_q[j][NumW-2:0], sy[0]};
        nz_q[j+1] <= {nz_q[j][NumW-2:0], sz[0]};
      end
    end
  end

  logic zl;
  assign zl = len_q[DivBits] == '0;
  assign valid_o = v_q[Tot-1];
  assign unit_x_o = zl ? '0 : (sg_q[DivBits][0] ? 16'(-nx_q[DivBits]) : 16'(nx_q[DivBits]));
  assign unit_y_o = zl ? '0 : (sg_q[DivBits][1] ? 16'(-ny_q[DivBits]) : 16'(ny_q[DivBits]));
  assign unit_z_o = zl ? '0 : (sg_q[DivBits][2] ? 16'(-nz_q[DivBits]) : 16'(nz_q[DivBits]));
  assign magnitude_o = len_q[DivBits][15:0];
  assign zero_length_o = zl;
endmodule

// File: hdl/vector3_normalize_top.sv
// Top level of the 3D vector normalizer.
// Input channel: drive in_x_i, in_y_i, in_z_i and push; a beat is taken when
// push is high and full is low. Result channel: while empty is low the oldest
// result (unit_x_o, unit_y_o, unit_z_o, magnitude_o, zero_length_o) is shown,
// and it is taken when pop is high.
// A two-stage front squares and sums the components into a small queue.
// The back pipeline takes 16 stages of square root, one result bit each, and
// 30 stages of restoring division for all three components in parallel,
// followed by an eight-entry output queue.
// Throughput is one vector per cycle while the receiver keeps popping.
// When the receiver stalls, the output queue fills; the back pipeline then
// holds, the middle queue fills, the front holds and full rises.
// Reset empties all queues and clears every valid flag; no clearing pass.
// A zero vector returns zero components, zero magnitude and zero_length set.
module vector3_normalize_top #(
  parameter int unsigned QueueDepth = vn_pkg::DefaultQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_x_i,
  input  logic [15:0] in_y_i,
  input  logic [15:0] in_z_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] unit_x_o,
  output logic [15:0] unit_y_o,
  output logic [15:0] unit_z_o,
  output logic [15:0] magnitude_o,
  output logic        zero_length_o
);
  import vn_pkg::*;
  localparam int unsigned OutDepth = 8;
  localparam int unsigned OW = $clog2(OutDepth);
  localparam int unsigned OCW = $clog2(OutDepth + 1);
  localparam int unsigned CW = $clog2(QueueDepth + 1);

  logic fv, fstall, mfull, mempty, bvalid, bstall, bpop;
  vn_front_t fdata, mdata;
  logic [CW-1:0] mcnt;
  logic [15:0] ux, uy, uz, mg;
  logic zl;

  vn_front u_front (.clk_i, .rst_ni, .valid_i(push && !full), .x_i(in_x_i),
    .y_i(in_y_i), .z_i(in_z_i), .stall_i(fstall), .valid_o(fv), .data_o(fdata));

  assign fstall = fv && mfull;
  assign full = fstall;

  vn_queue #(.Depth(QueueDepth)) u_queue (.clk_i, .rst_ni, .push_i(fv),
    .data_i(fdata), .full_o(mfull), .empty_o(mempty), .pop_i(bpop),
    .data_o(mdata), .count_o(mcnt));

  // The back pipeline holds as a whole while the output queue is full.
  logic [OCW-1:0] ocnt_q;
  assign bstall = ocnt_q == OCW'(OutDepth);
  assign bpop = !mempty && !bstall;

  vn_back u_back (.clk_i, .rst_ni, .valid_i(bpop), .data_i(mdata),
    .stall_i(bstall), .valid_o(bvalid), .unit_x_o(ux), .unit_y_o(uy),
    .unit_z_o(uz), .magnitude_o(mg), .zero_length_o(zl));

  logic [64:0] omem_q [OutDepth];
  logic [OW-1:0] owr_q, ord_q;
  logic opush, opop;
  assign opush = bvalid && !bstall;
  assign opop = pop && !empty;
  assign empty = ocnt_q == '0;
  assign {unit_x_o, unit_y_o, unit_z_o, magnitude_o, zero_length_o} = omem_q[ord_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q <= '0;
      ord_q <= '0;
      ocnt_q <= '0;
    end else begin
      if (opush) owr_q <= owr_q + 1'b1;
      if (opop) ord_q <= ord_q + 1'b1;
      ocnt_q <= ocnt_q + OCW'(opush) - OCW'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (opush) omem_q[owr_q] <= {ux, uy, uz, mg, zl};
  end

  logic unused;
  assign unused = ^mcnt;
endmodule

// File: hdl/vector3_normalize_checker.sv
// Port-level checker for the vector normalizer, bound to the top level.
module vector3_normalize_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [15:0] unit_x_o,
  input logic [15:0] magnitude_o,
  input logic        zero_length_o
);
  a_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && zero_length_o |-> magnitude_o == '0 && unit_x_o == '0)
    else $error("zero length with nonzero fields");
  a_mag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !zero_length_o |-> magnitude_o != '0)
    else $error("zero magnitude without flag");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(magnitude_o))
    else $error("result changed while stalled");
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("results present during reset");
endmodule

bind vector3_normalize_top vector3_normalize_checker u_checker (.*);
